// ----- hdl/orbit_camera_position_top_assert.svh -----
// Assertion macros for the orbit camera block
`ifndef ORBIT_CAMERA_POSITION_TOP_ASSERT_SVH
`define ORBIT_CAMERA_POSITION_TOP_ASSERT_SVH
`ifndef ASSERT_OFF
`define OCP_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define OCP_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define OCP_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define OCP_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ----- hdl/ocam_pkg.sv -----
`timescale 1ns / 1ps
package ocam_pkg;
  localparam int unsigned CordicSteps = 20;
  localparam int unsigned StepW = 5;
  localparam logic signed [33:0] Deg90 = 34'sd5898240;
  localparam logic signed [33:0] Deg180 = 34'sd11796480;
  localparam logic signed [33:0] Deg360 = 34'sd23592960;
  localparam logic signed [33:0] CordicK = 34'sd652032874;
  localparam logic signed [33:0] StepQ = 34'sd13107;
  localparam logic signed [17:0] PitchGain = 18'sd6554;
  localparam logic signed [17:0] OrbitGain = 18'sd19661;

  typedef enum logic [2:0] {
    MODE_MOVE, MODE_ZOOM, MODE_PITCH, MODE_ORBIT,
    MODE_RECOMP, MODE_LOWER, MODE_INVERT, MODE_RESTART
  } mode_e;

  typedef enum logic [2:0] {
    DIR_FWD, DIR_RIGHT, DIR_LEFT, DIR_BACK, DIR_UP, DIR_DOWN, DIR_NONE6, DIR_NONE7
  } dir_e;

  typedef enum logic [1:0] {
    CFG_DIST = 2'd0, CFG_PITCH = 2'd1, CFG_ANGLE = 2'd2
  } cfg_e;

  typedef enum logic [3:0] {
    ST_IDLE, ST_PREP, ST_RED_P, ST_COR_P, ST_HD, ST_VD, ST_RED_T, ST_COR_T,
    ST_PX, ST_PZ, ST_FIN, ST_OUT
  } state_e;

  typedef struct packed {
    logic start;
    logic signed [33:0] angle;
  } cordic_req_t;

  typedef struct packed {
    logic done;
    logic signed [33:0] sin_v;
    logic signed [33:0] cos_v;
  } cordic_rsp_t;

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    if (v > 66'sd2147483647) return 32'sh7fffffff;
    if (v < -66'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic logic signed [33:0] atan_q(input logic [StepW-1:0] i);
    case (i)
      5'd0: return 34'sd2949120;  5'd1: return 34'sd1740967;
      5'd2: return 34'sd919879;   5'd3: return 34'sd466945;
      5'd4: return 34'sd234379;   5'd5: return 34'sd117305;
      5'd6: return 34'sd58666;    5'd7: return 34'sd29335;
      5'd8: return 34'sd14668;    5'd9: return 34'sd7334;
      5'd10: return 34'sd3667;    5'd11: return 34'sd1833;
      5'd12: return 34'sd917;     5'd13: return 34'sd458;
      5'd14: return 34'sd229;     5'd15: return 34'sd115;
      5'd16: return 34'sd57;      5'd17: return 34'sd29;
      5'd18: return 34'sd14;      5'd19: return 34'sd7;
      default: return 34'sd0;
    endcase
  endfunction
endpackage

// ----- hdl/ocam_cordic.sv -----
`timescale 1ns / 1ps
module ocam_cordic (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  ocam_pkg::cordic_req_t req_i,
  output ocam_pkg::cordic_rsp_t rsp_o
);
  // angle is already reduced to [-180,180); fold, then one rotation per cycle
  logic signed [33:0] x_q, x_d, y_q, y_d, z_q, z_d;
  logic [ocam_pkg::StepW-1:0] i_q, i_d;
  logic busy_q, busy_d, neg_q, neg_d, done_q, done_d;
  logic signed [33:0] xs, ys;

  always_comb begin
    x_d = x_q; y_d = y_q; z_d = z_q; i_d = i_q;
    busy_d = busy_q; neg_d = neg_q; done_d = 1'b0;
    xs = x_q >>> i_q;
    ys = y_q >>> i_q;
    if (req_i.start) begin
      x_d = ocam_pkg::CordicK; y_d = '0; i_d = '0; busy_d = 1'b1; neg_d = 1'b0;
      z_d = req_i.angle;
      if (req_i.angle > ocam_pkg::Deg90) begin
        z_d = req_i.angle - ocam_pkg::Deg180; neg_d = 1'b1;
      end else if (req_i.angle < -ocam_pkg::Deg90) begin
        z_d = req_i.angle + ocam_pkg::Deg180; neg_d = 1'b1;
      end
    end else if (busy_q) begin
      if (!z_q[33]) begin
        x_d = x_q - ys; y_d = y_q + xs; z_d = z_q - ocam_pkg::atan_q(i_q);
      end else begin
        x_d = x_q + ys; y_d = y_q - xs; z_d = z_q + ocam_pkg::atan_q(i_q);
      end
      i_d = i_q + 1'b1;
      if (i_q == ocam_pkg::StepW'(ocam_pkg::CordicSteps - 1)) begin
        busy_d = 1'b0; done_d = 1'b1;
        if (neg_q) begin
          x_d = -x_d; y_d = -y_d;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; done_q <= 1'b0; i_q <= '0; neg_q <= 1'b0;
    end else begin
      busy_q <= busy_d; done_q <= done_d; i_q <= i_d; neg_q <= neg_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d; y_q <= y_d; z_q <= z_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.sin_v = y_q;
  assign rsp_o.cos_v = x_q;
endmodule

// ----- hdl/orbit_camera_position_top.sv -----
`timescale 1ns / 1ps
// channel  dir  handshake            payload
// s_axis   in   s_axis_tvalid/tready  tdata 160b: mode,direction,amount,px,py,pz,heading
// m_axis   out  m_axis_tvalid/tready  tdata 160b: cam_x,cam_y,cam_z,cam_pitch,cam_yaw
// cfg      in   cfg_we_i              cfg_idx_i, cfg_data_i (31b)
// A recompute event runs two 20-step CORDIC passes on the shared rotator, one
// multiply state per product and control steps, plus the 360 degree reduction
// steps of pitch and of heading plus orbit angle (up to 91 and 92 steps for
// extreme angles). Other events go from ST_PREP straight to ST_OUT.
// Reset is asynchronous active low and loads the start values.
// One result can wait in the output register while the next request is computed;
// a second finished result holds the sequencer until the first has left.
`include "orbit_camera_position_top_assert.svh"
module orbit_camera_position_top (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // mode[2:0] direction[5:3] amount[37:6] player_x[69:38] player_y[101:70]
  // player_z[133:102] player_heading[159:134]
  input  logic [159:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // cam_x[31:0] cam_y[63:32] cam_z[95:64] cam_pitch[127:96] cam_yaw[159:128]
  output logic [159:0] m_axis_tdata,
  input  logic         cfg_we_i,
  input  logic [1:0]   cfg_idx_i,
  input  logic [30:0]  cfg_data_i
);
  ocam_pkg::state_e st_q, st_d;
  logic [30:0] cdist_q;
  logic [23:0] cpitch_q;
  logic [25:0] cangle_q;
  logic signed [31:0] dist_q, dist_d, pitch_q, pitch_d, orb_q, orb_d;
  logic signed [31:0] px_q, px_d, py_q, py_d, pz_q, pz_d, yaw_q, yaw_d;
  logic signed [31:0] hd_q, hd_d, vd_q, vd_d;
  logic signed [33:0] red_q, red_d, theta_q, theta_d;
  logic [159:0] in_q;
  logic [159:0] out_q, out_d;
  logic out_v_q, out_v_d;
  logic signed [65:0] prod;
  logic signed [31:0] mul_a;
  logic signed [33:0] mul_b;
  ocam_pkg::cordic_req_t creq;
  ocam_pkg::cordic_rsp_t crsp;

  logic [2:0] f_mode, f_dir;
  logic signed [31:0] f_amt, f_px, f_py, f_pz;
  logic signed [25:0] f_hd;
  assign f_mode = in_q[2:0];
  assign f_dir = in_q[5:3];
  assign f_amt = in_q[37:6];
  assign f_px = in_q[69:38];
  assign f_py = in_q[101:70];
  assign f_pz = in_q[133:102];
  assign f_hd = in_q[159:134];

  ocam_cordic u_cordic (.clk_i, .rst_ni, .req_i(creq), .rsp_o(crsp));

  // shared multiplier, product rounded at bit 30
  assign prod = (66'(mul_a) * 66'(mul_b) + 66'sd536870912) >>> 30;

  always_comb begin
    st_d = st_q; dist_d = dist_q; pitch_d = pitch_q; orb_d = orb_q;
    px_d = px_q; py_d = py_q; pz_d = pz_q; yaw_d = yaw_q;
    hd_d = hd_q; vd_d = vd_q; red_d = red_q; theta_d = theta_q;
    out_v_d = out_v_q; out_d = out_q;
    if (out_v_q && m_axis_tready) out_v_d = 1'b0;
    creq.start = 1'b0; creq.angle = red_q;
    mul_a = dist_q; mul_b = crsp.cos_v;
    case (st_q)
      ocam_pkg::ST_IDLE: begin
        if (s_axis_tvalid) st_d = ocam_pkg::ST_PREP;
      end
      ocam_pkg::ST_PREP: begin
        st_d = ocam_pkg::ST_OUT;
        case (ocam_pkg::mode_e'(f_mode))
          ocam_pkg::MODE_MOVE: begin
            case (ocam_pkg::dir_e'(f_dir))
              ocam_pkg::DIR_FWD: pz_d = ocam_pkg::sat32(66'(pz_q) - 66'(ocam_pkg::StepQ));
              ocam_pkg::DIR_RIGHT: px_d = ocam_pkg::sat32(66'(px_q) + 66'(ocam_pkg::StepQ));
              ocam_pkg::DIR_LEFT: px_d = ocam_pkg::sat32(66'(px_q) - 66'(ocam_pkg::StepQ));
              ocam_pkg::DIR_BACK: pz_d = ocam_pkg::sat32(66'(pz_q) + 66'(ocam_pkg::StepQ));
              ocam_pkg::DIR_UP: py_d = ocam_pkg::sat32(66'(py_q) + 66'(ocam_pkg::StepQ));
              ocam_pkg::DIR_DOWN: py_d = ocam_pkg::sat32(66'(py_q) - 66'(ocam_pkg::StepQ));
              default: ;
            endcase
          end
          ocam_pkg::MODE_ZOOM: begin
            dist_d = ocam_pkg::sat32(66'(dist_q) - 66'(f_amt));
            st_d = ocam_pkg::ST_RED_P;
          end
          ocam_pkg::MODE_PITCH: begin
            pitch_d = ocam_pkg::sat32(66'(pitch_q) - 66'(ocam_pkg::sat32(
              (66'(f_amt) * 66'(ocam_pkg::PitchGain) + 66'sd32768) >>> 16)));
            st_d = ocam_pkg::ST_RED_P;
          end
          ocam_pkg::MODE_ORBIT: begin
            orb_d = ocam_pkg::sat32(66'(orb_q) - 66'(ocam_pkg::sat32(
              (66'(f_amt) * 66'(ocam_pkg::OrbitGain) + 66'sd32768) >>> 16)));
            st_d = ocam_pkg::ST_RED_P;
          end
          ocam_pkg::MODE_RECOMP: st_d = ocam_pkg::ST_RED_P;
          ocam_pkg::MODE_LOWER: py_d = ocam_pkg::sat32(66'(py_q) - 66'(f_amt));
          ocam_pkg::MODE_INVERT: pitch_d = ocam_pkg::sat32(-66'(pitch_q));
          default: begin
            dist_d = {1'b0, cdist_q};
            pitch_d = 32'(signed'(cpitch_q));
            orb_d = 32'(signed'(cangle_q));
          end
        endcase
        red_d = 34'(pitch_d);
        theta_d = 34'(f_hd) + 34'(orb_d);
      end
      ocam_pkg::ST_RED_P, ocam_pkg::ST_RED_T: begin
        // reduce to [-180,180) with compare/subtract steps of 360
        if (red_q >= ocam_pkg::Deg180) red_d = red_q - ocam_pkg::Deg360;
        else if (red_q < -ocam_pkg::Deg180) red_d = red_q + ocam_pkg::Deg360;
        else begin
          creq.start = 1'b1;
          st_d = (st_q == ocam_pkg::ST_RED_P) ? ocam_pkg::ST_COR_P : ocam_pkg::ST_COR_T;
        end
      end
      ocam_pkg::ST_COR_P: if (crsp.done) st_d = ocam_pkg::ST_HD;
      ocam_pkg::ST_HD: begin
        hd_d = ocam_pkg::sat32(prod); st_d = ocam_pkg::ST_VD;
      end
      ocam_pkg::ST_VD: begin
        mul_b = crsp.sin_v;
        vd_d = ocam_pkg::sat32(prod);
        red_d = theta_q; st_d = ocam_pkg::ST_RED_T;
      end
      ocam_pkg::ST_COR_T: if (crsp.done) st_d = ocam_pkg::ST_PX;
      ocam_pkg::ST_PX: begin
        mul_a = hd_q; mul_b = crsp.sin_v;
        px_d = ocam_pkg::sat32(66'(f_px) - 66'(ocam_pkg::sat32(prod)));
        st_d = ocam_pkg::ST_PZ;
      end
      ocam_pkg::ST_PZ: begin
        mul_a = hd_q;
        pz_d = ocam_pkg::sat32(66'(f_pz) - 66'(ocam_pkg::sat32(prod)));
        st_d = ocam_pkg::ST_FIN;
      end
      ocam_pkg::ST_FIN: begin
        py_d = ocam_pkg::sat32(66'(f_py) + 66'(vd_q));
        yaw_d = ocam_pkg::sat32(66'(ocam_pkg::Deg180) - 66'(theta_q));
        st_d = ocam_pkg::ST_OUT;
      end
      ocam_pkg::ST_OUT: begin
        if (!out_v_q || m_axis_tready) begin
          out_v_d = 1'b1;
          out_d = {yaw_q, pitch_q, pz_q, py_q, px_q};
          st_d = ocam_pkg::ST_IDLE;
        end
      end
      default: st_d = ocam_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ocam_pkg::ST_IDLE; out_v_q <= 1'b0; out_q <= '0;
      cdist_q <= 31'd3276800; cpitch_q <= 24'sd1310720; cangle_q <= '0;
      dist_q <= 32'sd3276800; pitch_q <= 32'sd1310720; orb_q <= '0;
      px_q <= '0; py_q <= '0; pz_q <= '0; yaw_q <= '0;
    end else begin
      st_q <= st_d; out_v_q <= out_v_d; out_q <= out_d;
      dist_q <= dist_d; pitch_q <= pitch_d; orb_q <= orb_d;
      px_q <= px_d; py_q <= py_d; pz_q <= pz_d; yaw_q <= yaw_d;
      if (cfg_we_i) begin
        case (ocam_pkg::cfg_e'(cfg_idx_i))
          ocam_pkg::CFG_DIST: cdist_q <= cfg_data_i;
          ocam_pkg::CFG_PITCH: cpitch_q <= cfg_data_i[23:0];
          ocam_pkg::CFG_ANGLE: cangle_q <= cfg_data_i[25:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    hd_q <= hd_d; vd_q <= vd_d; red_q <= red_d; theta_q <= theta_d;
    if (s_axis_tvalid && s_axis_tready) in_q <= s_axis_tdata;
  end

  assign s_axis_tready = (st_q == ocam_pkg::ST_IDLE);
  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata = out_q;

  `OCP_ASSERT_IMP(a_busy_no_rdy, clk_i, rst_ni, st_q != ocam_pkg::ST_IDLE, !s_axis_tready)
  `OCP_ASSERT_NXT(a_acc_busy, clk_i, rst_ni, s_axis_tvalid && s_axis_tready, !s_axis_tready)
  `OCP_ASSERT_NXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))
endmodule
